// File: design/htd_pkg.sv
`default_nettype none
package htd_pkg;

	localparam int NODE_IW  = 9;
	localparam int WEIGHT_W = 40;
	localparam int FREQ_W   = 32;
	localparam int COUNT_W  = 40;

	localparam logic [1:0] KIND_LOAD  = 2'd0;
	localparam logic [1:0] KIND_BUILD = 2'd1;
	localparam logic [1:0] KIND_BIT   = 2'd2;

	localparam logic [NODE_IW-1:0] INNER_MARK = 9'd256;

	typedef struct packed {
		logic [NODE_IW-1:0] sym;
		logic [NODE_IW-1:0] left;
		logic [NODE_IW-1:0] right;
	} node_t;

	typedef struct packed {
		logic [NODE_IW-1:0]  node;
		logic [WEIGHT_W-1:0] weight;
	} heap_t;

endpackage
`default_nettype wire

// File: design/htd_req_if.sv
`default_nettype none
interface htd_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  symbol_index;
	logic [31:0] frequency;
	logic [39:0] symbol_count;
	logic        code_bit;

	modport source (output valid, kind, symbol_index, frequency, symbol_count, code_bit,
		input ready);
	modport sink (input valid, kind, symbol_index, frequency, symbol_count, code_bit,
		output ready);
endinterface
`default_nettype wire

// File: design/htd_rsp_if.sv
`default_nettype none
interface htd_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] symbol;
	logic       last;

	modport source (output valid, symbol, last, input ready);
	modport sink (input valid, symbol, last, output ready);
endinterface
`default_nettype wire

// File: design/huffman_tree_decoder.sv
`default_nettype none
// Huffman decoder fed by a byte frequency table. A load request writes one
// table entry. A build request scans the table and builds the tree through a
// min-heap held in a two-read-port memory, with a read state and a compare
// state for each heap level while an entry rises or sinks; no request is taken
// until the build ends. A code-bit request goes through the registered read
// of the node memory before its node is checked; a bit that is ignored leaves
// the block idle. A leaf result waits in an output
// register while the next request is taken, and a further leaf holds the input
// until that register is free. The frequency table reads as zero after reset;
// node and heap memories need no clearing pass.
module huffman_tree_decoder
	import htd_pkg::*;
#(
	parameter int SYMBOLS    = 256,
	parameter int HEAP_SLOTS = 512
) (
	input  wire        clk,
	input  wire        arst_n,
	htd_req_if.sink    req,
	htd_rsp_if.source  rsp
);

	localparam int NODE_SLOTS = 2 * SYMBOLS - 1;
	localparam int NW = $clog2(NODE_SLOTS);
	localparam int SW = $clog2(SYMBOLS);
	localparam int HW = $clog2(HEAP_SLOTS);
	localparam int CW = $clog2(HEAP_SLOTS + 1);

	typedef enum logic [4:0] {
		S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_SCAN_NEXT, S_INS_RD, S_INS_CMP, S_MERGE_CHK,
		S_TAKE_RD, S_TAKE_TOP, S_SINK_RD, S_SINK_CMP, S_TAKE_DONE, S_TWIN, S_ROOT_WR,
		S_ROOT_RD, S_ROOT_WAIT, S_DEC_CHK
	} state_t;

	typedef enum logic [1:0] {STEP_ONLY, STEP_A, STEP_B, STEP_ROOT} step_t;

	logic [FREQ_W-1:0] ftab [SYMBOLS];
	logic [SYMBOLS-1:0] fvld_q;
	logic [FREQ_W-1:0] f_rd_q;
	logic f_rdv_q;
	node_t nmem [NODE_SLOTS];
	node_t n_rd_q;
	heap_t hmem [HEAP_SLOTS];
	heap_t h_rda_q, h_rdb_q;

	state_t state_q;
	step_t step_q;
	logic scan_q, tree_ready_q;
	logic [SW-1:0] s_q;
	logic [NODE_IW-1:0] nodes_q, sym_q, next_q;
	logic [CW-1:0] size_q;
	logic [HW-1:0] pos_q;
	heap_t key_q, x_q, top_q, a_q;
	node_t root_q, cur_q;
	logic [COUNT_W-1:0] wanted_q, decoded_q;
	logic rsp_valid_q, rsp_last_q;
	logic [7:0] rsp_sym_q;

	logic f_re, n_re, n_we, ha_re, hb_re, h_we;
	logic [SW-1:0] f_ra;
	logic [NW-1:0] n_ra, n_wa;
	node_t n_wd;
	logic [HW-1:0] ha_ra, hb_ra, h_wa;
	heap_t h_wd;

	logic req_acc, load_ok, f_used, rsp_load;
	logic [NODE_IW-1:0] dec_next;
	logic [HW:0] l_idx, r_idx;
	logic l_ok, r_ok, pick_l, pick_r;
	logic [WEIGHT_W-1:0] w_pick, w_sum;
	logic [NODE_IW-1:0] twin_idx;

	assign req.ready = (state_q == S_IDLE);
	assign req_acc   = req.valid && req.ready;
	assign load_ok   = {1'b0, req.symbol_index} < 9'(SYMBOLS);
	assign f_used    = f_rdv_q && (f_rd_q != '0);
	assign rsp_load  = (state_q == S_DEC_CHK) && !n_rd_q.sym[NODE_IW-1] &&
		(!rsp_valid_q || rsp.ready);
	assign rsp.valid  = rsp_valid_q;
	assign rsp.symbol = rsp_sym_q;
	assign rsp.last   = rsp_last_q;

	always_comb begin
		dec_next = req.code_bit ? cur_q.right : cur_q.left;
		if (dec_next >= NODE_IW'(NODE_SLOTS)) begin
			dec_next = '0;
		end
	end

	assign l_idx  = {pos_q, 1'b1};
	assign r_idx  = l_idx + (HW+1)'(1);
	assign l_ok   = (HW+2)'(l_idx) < (HW+2)'(size_q);
	assign r_ok   = (HW+2)'(r_idx) < (HW+2)'(size_q);
	assign pick_l = l_ok && (h_rda_q.weight < x_q.weight);
	assign w_pick = pick_l ? h_rda_q.weight : x_q.weight;
	assign pick_r = r_ok && (h_rdb_q.weight < w_pick);
	assign w_sum  = a_q.weight + top_q.weight;
	assign twin_idx = nodes_q - NODE_IW'(1);

	always_comb begin
		f_re = 1'b0; f_ra = s_q;
		n_re = 1'b0; n_ra = next_q[NW-1:0];
		n_we = 1'b0; n_wa = nodes_q[NW-1:0]; n_wd = '0;
		ha_re = 1'b0; ha_ra = '0;
		hb_re = 1'b0; hb_ra = '0;
		h_we = 1'b0; h_wa = pos_q; h_wd = key_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_acc && req.kind == KIND_BIT) begin
					n_re = 1'b1;
					n_ra = dec_next[NW-1:0];
				end
			end
			S_SCAN_RD: f_re = 1'b1;
			S_SCAN_CHK: begin
				n_we = f_used;
				n_wd = '{sym: NODE_IW'(s_q), left: '0, right: '0};
			end
			S_INS_RD: begin
				if (pos_q == '0) begin
					h_we = 1'b1;
				end else begin
					ha_re = 1'b1;
					ha_ra = (pos_q - HW'(1)) >> 1;
				end
			end
			S_INS_CMP: begin
				h_we = 1'b1;
				if (h_rda_q.weight > key_q.weight) begin
					h_wd = h_rda_q;
				end
			end
			S_TAKE_RD: begin
				ha_re = 1'b1;
				hb_re = 1'b1;
				hb_ra = HW'(size_q - CW'(1));
			end
			S_SINK_RD: begin
				ha_re = 1'b1;
				ha_ra = l_idx[HW-1:0];
				hb_re = 1'b1;
				hb_ra = r_idx[HW-1:0];
			end
			S_SINK_CMP: begin
				h_we = 1'b1;
				h_wd = pick_r ? h_rdb_q : (pick_l ? h_rda_q : x_q);
			end
			S_TAKE_DONE: begin
				if (step_q == STEP_B) begin
					n_we = 1'b1;
					n_wd = '{sym: INNER_MARK, left: a_q.node, right: top_q.node};
				end
			end
			S_TWIN: begin
				n_we = 1'b1;
				n_wd = '{sym: sym_q, left: '0, right: '0};
			end
			S_ROOT_WR: begin
				n_we = 1'b1;
				n_wd = '{sym: INNER_MARK, left: top_q.node, right: twin_idx};
			end
			S_ROOT_RD: begin
				n_re = 1'b1;
				n_ra = top_q.node[NW-1:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (req_acc && req.kind == KIND_LOAD && load_ok) begin
			ftab[req.symbol_index[SW-1:0]] <= req.frequency;
		end
		if (f_re) begin
			f_rd_q  <= ftab[f_ra];
			f_rdv_q <= fvld_q[f_ra];
		end
		if (n_we) begin
			nmem[n_wa] <= n_wd;
		end
		if (n_re) begin
			n_rd_q <= nmem[n_ra];
		end
		if (h_we) begin
			hmem[h_wa] <= h_wd;
		end
		if (ha_re) begin
			h_rda_q <= hmem[ha_ra];
		end
		if (hb_re) begin
			h_rdb_q <= hmem[hb_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fvld_q <= '0;
		end else if (req_acc && req.kind == KIND_LOAD && load_ok) begin
			fvld_q[req.symbol_index[SW-1:0]] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			step_q       <= STEP_A;
			scan_q       <= 1'b0;
			tree_ready_q <= 1'b0;
			s_q          <= '0;
			nodes_q      <= '0;
			size_q       <= '0;
			pos_q        <= '0;
			wanted_q     <= '0;
			decoded_q    <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_acc && req.kind == KIND_BUILD) begin
						wanted_q     <= req.symbol_count;
						decoded_q    <= '0;
						nodes_q      <= '0;
						size_q       <= '0;
						s_q          <= '0;
						scan_q       <= 1'b1;
						tree_ready_q <= 1'b0;
						state_q      <= S_SCAN_RD;
					end else if (req_acc && req.kind == KIND_BIT && tree_ready_q &&
						decoded_q < wanted_q) begin
						next_q  <= dec_next;
						state_q <= S_DEC_CHK;
					end
				end
				S_SCAN_RD: state_q <= S_SCAN_CHK;
				S_SCAN_CHK: begin
					if (f_used) begin
						sym_q   <= NODE_IW'(s_q);
						nodes_q <= nodes_q + NODE_IW'(1);
						if (size_q < CW'(HEAP_SLOTS)) begin
							key_q   <= '{node: nodes_q, weight: WEIGHT_W'(f_rd_q)};
							pos_q   <= HW'(size_q);
							size_q  <= size_q + CW'(1);
							state_q <= S_INS_RD;
						end else begin
							state_q <= S_SCAN_NEXT;
						end
					end else begin
						state_q <= S_SCAN_NEXT;
					end
				end
				S_SCAN_NEXT: begin
					if (s_q == SW'(SYMBOLS - 1)) begin
						scan_q <= 1'b0;
						if (size_q == '0) begin
							state_q <= S_IDLE;
						end else begin
							step_q  <= (size_q == CW'(1)) ? STEP_ONLY : STEP_A;
							state_q <= S_TAKE_RD;
						end
					end else begin
						s_q     <= s_q + SW'(1);
						state_q <= S_SCAN_RD;
					end
				end
				S_INS_RD: begin
					if (pos_q == '0) begin
						state_q <= scan_q ? S_SCAN_NEXT : S_MERGE_CHK;
					end else begin
						state_q <= S_INS_CMP;
					end
				end
				S_INS_CMP: begin
					if (h_rda_q.weight > key_q.weight) begin
						pos_q   <= (pos_q - HW'(1)) >> 1;
						state_q <= S_INS_RD;
					end else begin
						state_q <= scan_q ? S_SCAN_NEXT : S_MERGE_CHK;
					end
				end
				S_MERGE_CHK: begin
					step_q  <= (size_q > CW'(1)) ? STEP_A : STEP_ROOT;
					state_q <= S_TAKE_RD;
				end
				S_TAKE_RD: state_q <= S_TAKE_TOP;
				S_TAKE_TOP: begin
					top_q   <= h_rda_q;
					x_q     <= h_rdb_q;
					size_q  <= size_q - CW'(1);
					pos_q   <= '0;
					state_q <= (size_q == CW'(1)) ? S_TAKE_DONE : S_SINK_RD;
				end
				S_SINK_RD: state_q <= S_SINK_CMP;
				S_SINK_CMP: begin
					if (pick_r) begin
						pos_q   <= r_idx[HW-1:0];
						state_q <= S_SINK_RD;
					end else if (pick_l) begin
						pos_q   <= l_idx[HW-1:0];
						state_q <= S_SINK_RD;
					end else begin
						state_q <= S_TAKE_DONE;
					end
				end
				S_TAKE_DONE: begin
					unique case (step_q)
						STEP_ONLY: state_q <= S_TWIN;
						STEP_A: begin
							a_q     <= top_q;
							step_q  <= STEP_B;
							state_q <= S_TAKE_RD;
						end
						STEP_B: begin
							key_q   <= '{node: nodes_q, weight: w_sum};
							nodes_q <= nodes_q + NODE_IW'(1);
							pos_q   <= HW'(size_q);
							size_q  <= size_q + CW'(1);
							state_q <= S_INS_RD;
						end
						STEP_ROOT: state_q <= S_ROOT_RD;
						default: state_q <= S_IDLE;
					endcase
				end
				S_TWIN: begin
					nodes_q <= nodes_q + NODE_IW'(1);
					state_q <= S_ROOT_WR;
				end
				S_ROOT_WR: begin
					root_q       <= n_wd;
					cur_q        <= n_wd;
					nodes_q      <= nodes_q + NODE_IW'(1);
					tree_ready_q <= 1'b1;
					state_q      <= S_IDLE;
				end
				S_ROOT_RD: state_q <= S_ROOT_WAIT;
				S_ROOT_WAIT: begin
					root_q       <= n_rd_q;
					cur_q        <= n_rd_q;
					tree_ready_q <= 1'b1;
					state_q      <= S_IDLE;
				end
				S_DEC_CHK: begin
					if (n_rd_q.sym[NODE_IW-1]) begin
						cur_q   <= n_rd_q;
						state_q <= S_IDLE;
					end else if (rsp_load) begin
						rsp_sym_q   <= n_rd_q.sym[7:0];
						rsp_last_q  <= (decoded_q + COUNT_W'(1)) == wanted_q;
						decoded_q   <= decoded_q + COUNT_W'(1);
						cur_q       <= root_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_root_inner: assert property (@(posedge clk) disable iff (!arst_n)
		(tree_ready_q && state_q == S_IDLE) |-> root_q.sym == INNER_MARK)
		else $error("root of a built tree is not an internal node");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		decoded_q <= wanted_q)
		else $error("decoded count passed the requested count");

	a_heap_bound: assert property (@(posedge clk) disable iff (!arst_n)
		size_q <= CW'(HEAP_SLOTS))
		else $error("heap size beyond its slots");

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) == S_DEC_CHK)
		else $error("result raised outside a leaf step");
`endif

endmodule
`default_nettype wire

// File: tb/sv/htd_tb_pkg.sv
`timescale 1ns / 100ps
package htd_tb_pkg;

	typedef struct packed {
		logic [7:0] symbol;
		logic       last;
	} decoded_t;

endpackage

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
module testbench;
	import htd_pkg::*;
	import htd_tb_pkg::*;

	localparam int NSYM  = 256;
	localparam int NNODE = 2 * NSYM - 1;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	htd_req_if req ();
	htd_rsp_if rsp ();

	huffman_tree_decoder i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	logic [31:0]  freq_tab [NSYM];
	logic [39:0]  nw       [NNODE];
	logic [8:0]   nl       [NNODE];
	logic [8:0]   nr       [NNODE];
	logic [8:0]   nsym     [NNODE];
	logic [8:0]   heap     [512];
	int           heap_n;
	int           nodes_n;
	logic [8:0]   root;
	logic [8:0]   cur;
	bit           built;
	logic [39:0]  done_cnt;
	logic [39:0]  want_cnt;

	decoded_t     symbols_due [$];
	int           errors = 0;
	int           cycles = 0;
	int           hold_off = 0;
	bit           hold_long = 1'b0;
	int           rsp_gap = 0;

	task automatic report(input string what);
		$display("mismatch at %0t: %s", $time, what);
		errors++;
	endtask

	function automatic logic [8:0] node_new(logic [8:0] s, logic [39:0] w,
		logic [8:0] l, logic [8:0] r);
		logic [8:0] k;
		if (nodes_n >= NNODE)
			return 9'd0;
		k = nodes_n[8:0];
		nodes_n++;
		nsym[k] = s;
		nw[k] = w;
		nl[k] = l;
		nr[k] = r;
		return k;
	endfunction

	function automatic logic [39:0] heap_w(int p);
		return nw[heap[p]];
	endfunction

	function automatic void heap_put(logic [8:0] k);
		int p;
		logic [8:0] t;
		if (heap_n >= 512)
			return;
		p = heap_n;
		heap_n++;
		heap[p] = k;
		while (p > 0 && heap_w((p - 1) / 2) > heap_w(p)) begin
			t = heap[p];
			heap[p] = heap[(p - 1) / 2];
			heap[(p - 1) / 2] = t;
			p = (p - 1) / 2;
		end
	endfunction

	function automatic logic [8:0] heap_get();
		logic [8:0] top;
		logic [8:0] t;
		int p;
		int pick;
		if (heap_n == 0)
			return 9'd0;
		p = 0;
		top = heap[0];
		heap_n--;
		heap[0] = heap[heap_n];
		forever begin
			pick = p;
			if (2 * p + 1 < heap_n && heap_w(2 * p + 1) < heap_w(pick))
				pick = 2 * p + 1;
			if (2 * p + 2 < heap_n && heap_w(2 * p + 2) < heap_w(pick))
				pick = 2 * p + 2;
			if (pick == p)
				break;
			t = heap[p];
			heap[p] = heap[pick];
			heap[pick] = t;
			p = pick;
		end
		return top;
	endfunction

	function automatic void tree_build(logic [39:0] count);
		logic [8:0] a;
		logic [8:0] b;
		want_cnt = count;
		done_cnt = '0;
		nodes_n = 0;
		heap_n = 0;
		for (int s = 0; s < NSYM; s++)
			if (freq_tab[s] != 0)
				heap_put(node_new(s[8:0], {8'd0, freq_tab[s]}, 9'd0, 9'd0));
		if (heap_n == 0) begin
			built = 1'b0;
			root = '0;
		end else if (heap_n == 1) begin
			a = heap_get();
			b = node_new(nsym[a], 40'd0, 9'd0, 9'd0);
			root = node_new(INNER_MARK, nw[a], a, b);
			built = 1'b1;
		end else begin
			while (heap_n > 1) begin
				a = heap_get();
				b = heap_get();
				heap_put(node_new(INNER_MARK, nw[a] + nw[b], a, b));
			end
			root = heap_get();
			built = 1'b1;
		end
		cur = root;
	endfunction

	function automatic void tree_walk(logic bitv);
		logic [8:0] nxt;
		decoded_t d;
		if (!built || done_cnt >= want_cnt)
			return;
		nxt = bitv ? nr[cur] : nl[cur];
		if (nsym[nxt] < INNER_MARK) begin
			done_cnt++;
			d.symbol = nsym[nxt][7:0];
			d.last = (done_cnt == want_cnt);
			symbols_due.push_back(d);
			cur = root;
		end else begin
			cur = nxt;
		end
	endfunction

	initial begin
		req.valid = 1'b0;
		req.kind = KIND_LOAD;
		req.symbol_index = '0;
		req.frequency = '0;
		req.symbol_count = '0;
		req.code_bit = 1'b0;
		rsp.ready = 1'b0;
		foreach (freq_tab[i])
			freq_tab[i] = '0;
		built = 1'b0;
		done_cnt = '0;
		want_cnt = '0;
	end

	task automatic send(input logic [1:0] k, input logic [7:0] idx, input logic [31:0] f,
		input logic [39:0] cnt, input logic b);
		int gap;
		gap = $urandom_range(0, 6);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap != 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.kind <= k;
		req.symbol_index <= idx;
		req.frequency <= f;
		req.symbol_count <= cnt;
		req.code_bit <= b;
		do
			@(posedge clk);
		while (!req.ready);
		case (k)
			KIND_LOAD: freq_tab[idx] = f;
			KIND_BUILD: tree_build(cnt);
			KIND_BIT: tree_walk(b);
			default: ;
		endcase
	endtask

	task automatic load(input logic [7:0] idx, input logic [31:0] f);
		send(KIND_LOAD, idx, f, 40'($urandom()), 1'($urandom()));
	endtask

	task automatic build(input logic [39:0] cnt);
		send(KIND_BUILD, 8'($urandom()), $urandom(), cnt, 1'($urandom()));
	endtask

	task automatic bits(input int n);
		for (int i = 0; i < n; i++)
			send(KIND_BIT, 8'($urandom()), $urandom(), 40'($urandom()),
				1'($urandom_range(0, 1)));
	endtask

	task automatic clear_table();
		for (int s = 0; s < NSYM; s++)
			if (freq_tab[s] != 0)
				load(s[7:0], 32'd0);
	endtask

	task automatic test_directed();
		bits(2);
		build(40'd5);
		bits(3);
		load(8'd7, 32'd9);
		build(40'd3);
		bits(4);
		load(8'd255, 32'hFFFF_FFFF);
		load(8'd0, 32'hFFFF_FFFF);
		load(8'd128, 32'd1);
		build(40'hFF_FFFF_FFFF);
		bits(6);
		load(8'd128, 32'd0);
		bits(2);
		send(KIND_UNUSED, 8'd1, 32'd1, 40'd1, 1'b1);
		build(40'd0);
		bits(2);
	endtask

	task automatic test_random_trees();
		int nsyms;
		int wide;
		for (int t = 0; t < 8; t++) begin
			clear_table();
			nsyms = (t == 7) ? 256 : $urandom_range(1, 12);
			wide = $urandom_range(0, 2);
			for (int i = 0; i < nsyms; i++)
				load((t == 7) ? i[7:0] : 8'($urandom()),
					wide == 0 ? $urandom_range(1, 4) :
					wide == 1 ? $urandom_range(1, 1000) : $urandom());
			build(40'($urandom_range(0, 3) == 0 ? $urandom_range(0, 3) :
				$urandom_range(4, 40)));
			for (int i = 0; i < 40; i++) begin
				if ($urandom_range(0, 15) == 0)
					load(8'($urandom()), $urandom());
				else if ($urandom_range(0, 40) == 0)
					send(KIND_UNUSED, 8'($urandom()), $urandom(), 40'($urandom()),
						1'($urandom()));
				else
					bits(1);
			end
		end
	endtask

	task automatic test_backpressure();
		clear_table();
		load(8'd10, 32'd1);
		load(8'd20, 32'd1);
		build(40'd100);
		hold_off = 60;
		hold_long = 1'b1;
		bits(40);
	endtask

	always @(posedge clk) begin
		if (hold_long) begin
			hold_off <= hold_off - 1;
			if (hold_off <= 1)
				hold_long <= 1'b0;
			rsp.ready <= 1'b0;
		end else if (arst_n) begin
			if (rsp.valid && rsp.ready)
				rsp_gap = $urandom_range(0, 6);
			else if (rsp_gap > 0)
				rsp_gap--;
			rsp.ready <= (rsp_gap == 0);
		end
	end

	always @(posedge clk) begin
		decoded_t got;
		decoded_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			got.symbol = rsp.symbol;
			got.last = rsp.last;
			if (symbols_due.size() == 0) begin
				report($sformatf("unexpected symbol %0d", got.symbol));
			end else begin
				want = symbols_due.pop_front();
				if (got.symbol !== want.symbol)
					report($sformatf("symbol %0d, want %0d", got.symbol, want.symbol));
				if (got.last !== want.last)
					report($sformatf("last %0b, want %0b", got.last, want.last));
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("huffman_tree_decoder regression: fail");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_random_trees();
		req.valid <= 1'b0;
		while (symbols_due.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0 && symbols_due.size() == 0)
			$display("huffman_tree_decoder regression: pass");
		else
			$display("huffman_tree_decoder regression: fail");
		$finish;
	end

endmodule

// File: filelist.f
design/htd_pkg.sv
design/htd_req_if.sv
design/htd_rsp_if.sv
design/huffman_tree_decoder.sv
tb/sv/htd_tb_pkg.sv
tb/sv/testbench.sv
